// ===== rtl/core/odr_pkg.sv =====
// odr_pkg: shared types, constants and tables for the dead-reckoning odometry block.
// Depends on nothing; imported by odr_ctrl, odr_dp and odometry_dead_reckoning.
package odr_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int POSE_WIDTH   = 32;

	localparam int CW     = 34;                   // CORDIC x/y/z width, Q2.30 plus headroom
	localparam int CNT_W  = $clog2(CORDIC_STEPS);
	localparam int NUM_W  = 49;                   // dividend width for the /1000 step
	localparam int DCNT_W = 1;                    // counter width for the /1000 step
	localparam int MA_W   = 33;
	localparam int MB_W   = 36;
	localparam int MP_W   = MA_W + MB_W;

	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [MB_W-1:0]      HEAD_K   = 36'd44798133900;

	// n/1000 = (n>>3)/125; (n>>3) = a*2^23 + b, 2^23 = 125*67108 + 108
	localparam logic [16:0] DIV_HI_K  = 17'd67108;
	localparam logic [6:0]  DIV_MID_K = 7'd108;
	localparam logic [30:0] DIV_RECIP = 31'd1099511628;   // ceil(2^37 / 125)
	localparam int          DIV_SH    = 37;

	localparam logic OPC_CMD  = 1'b0;
	localparam logic OPC_TICK = 1'b1;

	localparam logic [1:0] CFG_WATCHDOG = 2'd0;
	localparam logic [1:0] CFG_DEFSTEP  = 2'd1;
	localparam logic [1:0] CFG_MAXSTEP  = 2'd2;

	// datapath operations issued by the controller
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_CMD    = 4'd1;
	localparam logic [3:0] OP_TICK   = 4'd2;
	localparam logic [3:0] OP_COR_LD = 4'd3;
	localparam logic [3:0] OP_Q_LD   = 4'd4;
	localparam logic [3:0] OP_COR    = 4'd5;
	localparam logic [3:0] OP_M1     = 4'd6;
	localparam logic [3:0] OP_M2     = 4'd7;
	localparam logic [3:0] OP_DIV_LD = 4'd8;
	localparam logic [3:0] OP_DIV    = 4'd9;
	localparam logic [3:0] OP_ACC    = 4'd10;
	localparam logic [3:0] OP_H0     = 4'd11;
	localparam logic [3:0] OP_H1     = 4'd12;
	localparam logic [3:0] OP_H2     = 4'd13;
	localparam logic [3:0] OP_H3     = 4'd14;
	localparam logic [3:0] OP_OUT    = 4'd15;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	function automatic logic signed [CW-1:0] atan_at(input logic [4:0] i);
		atan_at = $signed({2'b00, ATAN_TAB[i]});
	endfunction

	typedef struct packed {
		logic               opcode;
		logic [31:0]        now_ms;
		logic signed [31:0] cmd_linear;
		logic signed [31:0] cmd_angular;
	} odr_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        heading_angle;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_z;
		logic signed [31:0] vel_linear;
		logic signed [31:0] vel_angular;
		logic               motor_stop;
	} odr_out_t;

	typedef struct packed {
		logic [3:0] op;
		logic       sel;   // 0 cos / x, 1 sin / y
	} odr_cmd_t;

	typedef struct packed {
		logic cor_last;
		logic div_last;
	} odr_stat_t;

endpackage

// ===== rtl/core/odr_ctrl.sv =====
// odr_ctrl: sequencer for the odometry tick, issues one datapath op per cycle.
// Depends on odr_pkg.
module odr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_opcode,
	output logic              out_valid,
	input  logic              out_ready,
	output odr_pkg::odr_cmd_t cmd,
	input  odr_pkg::odr_stat_t stat
);
	import odr_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_COR_LD = 4'd1;
	localparam logic [3:0] ST_COR    = 4'd2;
	localparam logic [3:0] ST_M1     = 4'd3;
	localparam logic [3:0] ST_M2     = 4'd4;
	localparam logic [3:0] ST_DIV_LD = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_ACC    = 4'd7;
	localparam logic [3:0] ST_H0     = 4'd8;
	localparam logic [3:0] ST_H1     = 4'd9;
	localparam logic [3:0] ST_H2     = 4'd10;
	localparam logic [3:0] ST_H3     = 4'd11;
	localparam logic [3:0] ST_Q_LD   = 4'd12;
	localparam logic [3:0] ST_Q      = 4'd13;
	localparam logic [3:0] ST_OUT    = 4'd14;

	logic [3:0] state_q, state_d;
	logic       sel_q, sel_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd.op  = OP_NONE;
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_opcode == OPC_TICK) begin
						cmd.op  = OP_TICK;
						state_d = ST_COR_LD;
						sel_d   = 1'b0;
					end else begin
						cmd.op = OP_CMD;
					end
				end
			end
			ST_COR_LD: begin
				cmd.op  = OP_COR_LD;
				state_d = ST_COR;
			end
			ST_COR: begin
				cmd.op = OP_COR;
				if (stat.cor_last) state_d = ST_M1;
			end
			ST_M1: begin
				cmd.op  = OP_M1;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.op  = OP_M2;
				state_d = ST_DIV_LD;
			end
			ST_DIV_LD: begin
				cmd.op  = OP_DIV_LD;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (stat.div_last) state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op = OP_ACC;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_M1;
				end else begin
					state_d = ST_H0;
				end
			end
			ST_H0: begin
				cmd.op  = OP_H0;
				state_d = ST_H1;
			end
			ST_H1: begin
				cmd.op  = OP_H1;
				state_d = ST_H2;
			end
			ST_H2: begin
				cmd.op  = OP_H2;
				state_d = ST_H3;
			end
			ST_H3: begin
				cmd.op  = OP_H3;
				state_d = ST_Q_LD;
			end
			ST_Q_LD: begin
				cmd.op  = OP_Q_LD;
				state_d = ST_Q;
			end
			ST_Q: begin
				cmd.op = OP_COR;
				if (stat.cor_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready)   out_valid_q <= 1'b0;
		end
	end

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_opcode == OPC_TICK) |=> (state_q == ST_COR_LD))
		else $error("tick accepted but sequence not started");
	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> (state_q == ST_OUT))
		else $error("result overwritten while previous still pending");
	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !stat.div_last) |=> (state_q == ST_DIV))
		else $error("divider left early");
	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result load did not raise valid");

endmodule

// ===== rtl/core/odr_dp.sv =====
// odr_dp: odometry datapath - state, config registers, shared CORDIC, multiplier,
// /1000 divider and output register. Depends on odr_pkg; driven by odr_ctrl.
module odr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  odr_pkg::odr_in_t   in_data,
	input  odr_pkg::odr_cmd_t  cmd,
	output odr_pkg::odr_stat_t stat,
	output odr_pkg::odr_out_t  out_data
);
	import odr_pkg::*;

	localparam int SUM_W = ((POSE_WIDTH > NUM_W + 1) ? POSE_WIDTH : NUM_W + 1) + 1;

	logic [15:0] watchdog_q, max_step_q;
	logic [9:0]  def_step_q;

	logic signed [31:0]           lin_q, ang_q;
	logic [31:0]                  last_tick_q, last_cmd_q, heading_q;
	logic signed [POSE_WIDTH-1:0] x_q, y_q;
	logic [15:0]                  dt_q;
	logic                         stop_q;

	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [CNT_W-1:0]     ccnt_q;
	logic                 cflip_q;

	logic [MP_W-1:0]   mul_q;
	logic [MA_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic              neg_q, hneg_q;
	logic [23:0]       ph_q;
	logic [59:0]       hlo_q;

	logic [NUM_W-1:0]  div_num_q;
	logic [39:0]       div_hi_q;
	logic [29:0]       div_lo_q;
	logic [DCNT_W-1:0] dcnt_q;

	odr_out_t out_q;

	// tick preparation
	logic [31:0] elapsed, since_cmd;
	logic        wd_fire;
	assign elapsed   = in_data.now_ms - last_tick_q;
	assign since_cmd = in_data.now_ms - last_cmd_q;
	assign wd_fire   = (since_cmd > {16'd0, watchdog_q}) && (lin_q != 0 || ang_q != 0);

	// CORDIC start angle and fold
	logic [31:0] cor_ang;
	logic        fold;
	assign cor_ang = (cmd.op == OP_Q_LD) ? {1'b0, heading_q[31:1]} : heading_q;
	assign fold    = cor_ang[31] ^ cor_ang[30];

	logic signed [CW-1:0] c_dx, c_dy, c_at;
	assign c_dx = cy_q >>> ccnt_q;
	assign c_dy = cx_q >>> ccnt_q;
	assign c_at = atan_at(5'(ccnt_q));

	logic signed [CW-1:0] cosv, sinv, trig;
	logic [CW-1:0]        trig_abs;
	assign cosv     = cflip_q ? -cx_q : cx_q;
	assign sinv     = cflip_q ? -cy_q : cy_q;
	assign trig     = cmd.sel ? sinv : cosv;
	assign trig_abs = trig[CW-1] ? CW'(-trig) : CW'(trig);

	logic [MA_W-1:0] lin_abs, ang_abs;
	assign lin_abs = lin_q[31] ? MA_W'(-33'(lin_q)) : MA_W'(33'(lin_q));
	assign ang_abs = ang_q[31] ? MA_W'(-33'(ang_q)) : MA_W'(33'(ang_q));

	always_comb begin
		mul_a = lin_abs;
		mul_b = MB_W'(trig_abs);
		case (cmd.op)
			OP_M2: begin
				mul_a = mul_q[62:30];
				mul_b = MB_W'(dt_q);
			end
			OP_DIV: begin
				mul_a = MA_W'(div_lo_q);
				mul_b = MB_W'(DIV_RECIP);
			end
			OP_H0: begin
				mul_a = ang_abs;
				mul_b = MB_W'(dt_q);
			end
			OP_H1: begin
				mul_a = MA_W'(mul_q[23:0]);
				mul_b = HEAD_K;
			end
			OP_H2: begin
				mul_a = MA_W'(ph_q);
				mul_b = HEAD_K;
			end
			default: begin
				mul_a = lin_abs;
				mul_b = MB_W'(trig_abs);
			end
		endcase
	end

	// divide by 1000: split n>>3 at bit 23, fold the high part by constants,
	// then a reciprocal multiply for the low residue
	logic [22:0] div_a, div_b;
	assign div_a = mul_q[48:26];
	assign div_b = mul_q[25:3];

	// saturating position add
	logic signed [SUM_W-1:0] d_ext, acc_ext, sum, pmax, pmin;
	logic signed [POSE_WIDTH-1:0] acc_sel, acc_new;
	assign d_ext   = neg_q ? -SUM_W'(div_num_q) : SUM_W'(div_num_q);
	assign acc_sel = cmd.sel ? y_q : x_q;
	assign acc_ext = SUM_W'(acc_sel);
	assign sum     = acc_ext + d_ext;
	assign pmax    = SUM_W'($signed({1'b0, {(POSE_WIDTH-1){1'b1}}}));
	assign pmin    = SUM_W'($signed({1'b1, {(POSE_WIDTH-1){1'b0}}}));
	assign acc_new = (sum > pmax) ? POSE_WIDTH'(pmax) :
	                 (sum < pmin) ? POSE_WIDTH'(pmin) : POSE_WIDTH'(sum);

	// heading increment from the two partial products
	logic [63:0] hsum;
	logic [31:0] hmag;
	assign hsum = {mul_q[39:0], 24'd0} + {4'd0, hlo_q};
	assign hmag = hsum[63:32];

	function automatic logic signed [31:0] sat32(input logic signed [POSE_WIDTH-1:0] v);
		logic signed [64:0] e;
		e = 65'(v);
		if (e > 65'sd2147483647)       sat32 = 32'sh7FFFFFFF;
		else if (e < -65'sd2147483648) sat32 = 32'sh80000000;
		else                           sat32 = 32'(e);
	endfunction

	function automatic logic signed [15:0] q14(input logic signed [CW-1:0] v);
		logic signed [CW:0] t;
		logic signed [CW:0] r;
		t = (CW+1)'(v) + 35'sd32768;
		r = t >>> 16;
		if (r > 35'sd16384)       q14 = 16'sd16384;
		else if (r < -35'sd16384) q14 = -16'sd16384;
		else                      q14 = 16'(r);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watchdog_q  <= 16'd500;
			def_step_q  <= 10'd50;
			max_step_q  <= 16'd1000;
			lin_q       <= '0;
			ang_q       <= '0;
			last_tick_q <= '0;
			last_cmd_q  <= '0;
			heading_q   <= '0;
			x_q         <= '0;
			y_q         <= '0;
			ccnt_q      <= '0;
			dcnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WATCHDOG: watchdog_q <= cfg_data;
					CFG_DEFSTEP:  def_step_q <= cfg_data[9:0];
					CFG_MAXSTEP:  max_step_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_CMD: begin
					lin_q      <= in_data.cmd_linear;
					ang_q      <= in_data.cmd_angular;
					last_cmd_q <= in_data.now_ms;
				end
				OP_TICK: begin
					last_tick_q <= in_data.now_ms;
					if (wd_fire) begin
						lin_q <= '0;
						ang_q <= '0;
					end
				end
				OP_COR_LD, OP_Q_LD: ccnt_q <= '0;
				OP_COR: ccnt_q <= ccnt_q + 1'b1;
				OP_DIV_LD: dcnt_q <= '0;
				OP_DIV: dcnt_q <= dcnt_q + 1'b1;
				OP_ACC: begin
					if (cmd.sel) y_q <= acc_new;
					else         x_q <= acc_new;
				end
				OP_H3: heading_q <= hneg_q ? heading_q - hmag : heading_q + hmag;
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TICK: begin
				dt_q   <= (elapsed == 32'd0 || elapsed > {16'd0, max_step_q}) ?
				          {6'd0, def_step_q} : elapsed[15:0];
				stop_q <= wd_fire;
			end
			OP_COR_LD, OP_Q_LD: begin
				cx_q    <= GAIN_Q30;
				cy_q    <= '0;
				cz_q    <= CW'($signed({cor_ang[31] ^ fold, cor_ang[30:0]}));
				cflip_q <= fold;
			end
			OP_COR: begin
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - c_dx;
					cy_q <= cy_q + c_dy;
					cz_q <= cz_q - c_at;
				end else begin
					cx_q <= cx_q + c_dx;
					cy_q <= cy_q - c_dy;
					cz_q <= cz_q + c_at;
				end
			end
			OP_M1: begin
				mul_q <= mul_a * mul_b;
				neg_q <= lin_q[31] ^ trig[CW-1];
			end
			OP_M2: mul_q <= mul_a * mul_b;
			OP_DIV_LD: begin
				div_hi_q <= 40'(div_a) * 40'(DIV_HI_K);
				div_lo_q <= 30'(div_a) * 30'(DIV_MID_K) + 30'(div_b);
			end
			OP_DIV: begin
				if (dcnt_q == DCNT_W'(0)) mul_q <= mul_a * mul_b;
				else div_num_q <= NUM_W'(div_hi_q) + NUM_W'(mul_q[60:DIV_SH]);
			end
			OP_H0: begin
				mul_q  <= mul_a * mul_b;
				hneg_q <= ang_q[31];
			end
			OP_H1: begin
				mul_q <= mul_a * mul_b;
				ph_q  <= mul_q[47:24];
			end
			OP_H2: begin
				mul_q <= mul_a * mul_b;
				hlo_q <= mul_q[59:0];
			end
			OP_OUT: begin
				out_q.pos_x         <= sat32(x_q);
				out_q.pos_y         <= sat32(y_q);
				out_q.heading_angle <= heading_q;
				out_q.quat_w        <= q14(cosv);
				out_q.quat_z        <= q14(sinv);
				out_q.vel_linear    <= lin_q;
				out_q.vel_angular   <= ang_q;
				out_q.motor_stop    <= stop_q;
			end
			default: ;
		endcase
	end

	assign stat.cor_last = (ccnt_q == CNT_W'(CORDIC_STEPS - 1));
	assign stat.div_last = (dcnt_q == DCNT_W'(1));
	assign out_data      = out_q;

endmodule

// ===== rtl/core/odometry_dead_reckoning.sv =====
// Dead-reckoning odometry: a command transaction is taken while idle and gives no result.
// A tick transaction runs two 16-step CORDIC passes (heading, then half heading); between
// them come the x/y passes, each with a /1000 divide, and the heading update.
// One transaction at a time; a tick's result waits in the output register while commands flow.
// arst_n clears pose, stored velocities and time stamps to zero and loads the register
// defaults (watchdog 500 ms, default step 50 ms, maximum step 1000 ms).
module odometry_dead_reckoning (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  odr_pkg::odr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output odr_pkg::odr_out_t out_data
);
	import odr_pkg::*;

	// controller to datapath: one op a cycle plus the cos/sin select
	odr_cmd_t  cmd;
	// datapath to controller: last CORDIC iteration, last divider cycle
	odr_stat_t stat;

	odr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (in_data.opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath also holds the config registers; writes land whenever cfg_we is high
	odr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for odometry_dead_reckoning: velocity commands and ticks are driven
// through valid/ready, and each pose result is checked against an in-bench integrator.
// Depends on odr_pkg and the odometry_dead_reckoning RTL only.
module testbench;
	import odr_pkg::*;

	localparam int          IDLE_LIMIT = 6000;   // cycles with no transaction before giving up
	localparam int          SETTLE     = 200;    // extra wait after the last owed pose is back
	localparam longint      UNIT_GAIN  = 64'd652032874;
	localparam bit [63:0]   TURN_K     = 64'd44798133900;
	localparam longint      ARCTAN [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	// Dead-reckoning integrator mirroring the block, plus the queue of poses still owed.
	class pose_scoreboard;
		int unsigned wd_ms = 500, def_step = 50, max_step = 1000;
		longint      x_pos, y_pos;
		bit [31:0]   heading;
		int          lin_v, ang_v;
		bit [31:0]   last_tick, last_cmd;
		odr_out_t    expected_poses[$];
		int          fails;

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == CFG_WATCHDOG) wd_ms = val;
			else if (idx == CFG_DEFSTEP) def_step = val[9:0];
			else if (idx == CFG_MAXSTEP) max_step = val;
		endfunction

		// rotation-mode CORDIC with half-turn folding of the outer quadrants
		function void rotate(bit [31:0] ang, output longint c, output longint s);
			bit [31:0] a;
			bit        flip;
			longint    x, y, z, dx, dy;
			a = ang;
			flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
			if (flip) a = a + 32'h80000000;
			z = $signed(a);
			x = UNIT_GAIN;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ARCTAN[i];
				end else begin
					x += dx; y -= dy; z += ARCTAN[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint travel(int v, longint trig, int unsigned dt);
			bit        neg;
			bit [63:0] mv, mt, m;
			neg = (v < 0) != (trig < 0);
			mv = (v < 0) ? -longint'(v) : longint'(v);
			mt = (trig < 0) ? -trig : trig;
			m = ((mv * mt) >> 30) * dt / 1000;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function bit [15:0] to_q14(longint v);
			longint r;
			r = (v + 32768) >>> 16;
			if (r > 16384) r = 16384;
			if (r < -16384) r = -16384;
			return r[15:0];
		endfunction

		function void note_item(odr_in_t it);
			int unsigned dt;
			bit [31:0]   since;
			bit          stop;
			longint      c, s, hc, hs, p;
			bit [63:0]   mp, ph, pl, a, mag;
			odr_out_t    r;
			if (it.opcode == OPC_CMD) begin
				lin_v = it.cmd_linear;
				ang_v = it.cmd_angular;
				last_cmd = it.now_ms;
				return;
			end
			dt = it.now_ms - last_tick;
			if (dt == 0 || dt > max_step) dt = def_step;
			last_tick = it.now_ms;
			since = it.now_ms - last_cmd;
			stop = 0;
			if (since > wd_ms && (lin_v != 0 || ang_v != 0)) begin
				lin_v = 0;
				ang_v = 0;
				stop = 1;
			end
			// position moves along the old heading
			rotate(heading, c, s);
			x_pos = clamp32(x_pos + travel(lin_v, c, dt));
			y_pos = clamp32(y_pos + travel(lin_v, s, dt));
			// heading: |w*dt| times 2^48/(2000*pi), shifted down by 32, split to keep 64-bit products
			p = longint'(ang_v) * longint'(dt);
			mp = (p < 0) ? -p : p;
			ph = mp >> 24;
			pl = mp & 64'hFFFFFF;
			a = ph * TURN_K;
			mag = (a >> 8) + ((((a & 64'hFF) << 24) + pl * TURN_K) >> 32);
			if (p < 0) heading = heading - mag[31:0];
			else heading = heading + mag[31:0];
			rotate({1'b0, heading[31:1]}, hc, hs);
			r.pos_x = x_pos[31:0];
			r.pos_y = y_pos[31:0];
			r.heading_angle = heading;
			r.quat_w = to_q14(hc);
			r.quat_z = to_q14(hs);
			r.vel_linear = lin_v;
			r.vel_angular = ang_v;
			r.motor_stop = stop;
			expected_poses.push_back(r);
		endfunction

		function void field(string name, bit [31:0] e, bit [31:0] a);
			if (e !== a) begin
				$error("%s: expected %h, got %h", name, e, a);
				fails++;
			end
		endfunction

		function void check_pose(odr_out_t got);
			odr_out_t e;
			if (expected_poses.size() == 0) begin
				$error("pose result with none outstanding");
				fails++;
				return;
			end
			e = expected_poses.pop_front();
			field("pos_x", e.pos_x, got.pos_x);
			field("pos_y", e.pos_y, got.pos_y);
			field("heading_angle", e.heading_angle, got.heading_angle);
			field("quat_w", e.quat_w, got.quat_w);
			field("quat_z", e.quat_z, got.quat_z);
			field("vel_linear", e.vel_linear, got.vel_linear);
			field("vel_angular", e.vel_angular, got.vel_angular);
			field("motor_stop", e.motor_stop, got.motor_stop);
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = CFG_WATCHDOG;
	logic [15:0] cfg_data = '0;
	logic       in_valid = 0;
	logic       in_ready;
	odr_in_t    in_data = '0;
	logic       out_valid;
	logic       out_ready = 0;
	odr_out_t   out_data;

	pose_scoreboard sb = new();
	bit          calm;        // last stretch: no idling on either side
	bit          hold_long;   // asks the receiver for one long hold-off
	bit [31:0]   clock_ms;    // running time stamp for generated transactions
	int          idle_cycles;

	odometry_dead_reckoning dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// output checking and the no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_pose(out_data);
			if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_ready <= 0;
				repeat (900) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1;
			repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
		end
	end

	// one register write; the task returns with the enable low
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// one transaction; valid stays up if the next one follows straight on
	task automatic send(odr_in_t it);
		in_data <= it;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic sendf(logic op, bit [31:0] t, bit [31:0] lin, bit [31:0] ang);
		odr_in_t it;
		it.opcode = op;
		it.now_ms = t;
		it.cmd_linear = lin;
		it.cmd_angular = ang;
		send(it);
	endtask

	// drop valid and wait until every owed pose is back, then let the pipe settle
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_poses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic bit [31:0] pick_velocity(int span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r <= 2) return $urandom;
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// mostly a steady stream of commands and ticks around 50 ms apart;
	// now and then a zero step, a long gap or a jump anywhere on the clock
	task automatic random_run(int count);
		int        r;
		bit [31:0] lin, ang;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4) clock_ms = $urandom;
			else if (r < 10) clock_ms = clock_ms;
			else if (r < 16) clock_ms += $urandom_range(0, 70000);
			else clock_ms += $urandom_range(1, 90);
			lin = pick_velocity(131072);
			ang = pick_velocity(262144);
			sendf(($urandom_range(0, 9) < 4) ? OPC_CMD : OPC_TICK, clock_ms, lin, ang);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults after reset
		sendf(OPC_TICK, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);      // zero step, command fields ignored
		sendf(OPC_CMD, 10, 32'h7FFFFFFF, 32'h80000000);      // both velocity extremes
		sendf(OPC_TICK, 60, 0, 0);
		sendf(OPC_TICK, 70000, 0, 0);                          // oversize step, watchdog stop
		sendf(OPC_TICK, 70400, 0, 0);                          // watchdog with nothing to stop
		for (int k = 1; k <= 4; k++) begin                     // full forward, then full reverse speed
			sendf(OPC_CMD, 71000 + k * 1000, (k < 3) ? 32'h7FFFFFFF : 32'h80000000, 0);
			sendf(OPC_TICK, 71001 + k * 1000, 0, 0);
		end
		sendf(OPC_CMD, 76000, 32'h00010000, 32'h7FFFFFFF);    // full-rate spin
		sendf(OPC_TICK, 76500, 0, 0);
		sendf(OPC_CMD, 32'hFFFFFFF0, 32'h80000000, 32'h00010000);
		sendf(OPC_TICK, 32'hFFFFFFFF, 0, 0);
		sendf(OPC_TICK, 32'h00000005, 0, 0);                  // time stamp wraps
		sendf(OPC_CMD, 32'h00000010, 0, 0);
		sendf(OPC_TICK, 32'h00000020, 0, 0);
		clock_ms = 32'h100;

		hold_long = 1;                                         // back-pressure while sending
		random_run(400);
		drain();

		// low extremes of every register
		write_reg(CFG_WATCHDOG, 16'd0);
		write_reg(CFG_DEFSTEP, 16'd1);
		write_reg(CFG_MAXSTEP, 16'd1);
		random_run(350);
		drain();

		// high extremes
		write_reg(CFG_WATCHDOG, 16'hFFFF);
		write_reg(CFG_DEFSTEP, 16'd1000);
		write_reg(CFG_MAXSTEP, 16'hFFFF);
		random_run(350);
		drain();

		// random settings, ending without any idling
		write_reg(CFG_WATCHDOG, 16'($urandom_range(0, 2000)));
		write_reg(CFG_DEFSTEP, 16'($urandom_range(1, 1000)));
		write_reg(CFG_MAXSTEP, 16'($urandom_range(1, 3000)));
		random_run(480);
		calm = 1;
		random_run(170);
		drain();

		if (sb.fails == 0 && sb.expected_poses.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== odometry_dead_reckoning.f =====
rtl/core/odr_pkg.sv
rtl/core/odr_ctrl.sv
rtl/core/odr_dp.sv
rtl/core/odometry_dead_reckoning.sv
tb/sv/testbench.sv
